### sv/psm_pkg.sv
package psm_pkg;

    // Default sizes of the machine.
    localparam int STACK_DEPTH_DEF = 1024;
    localparam int CODE_DEPTH_DEF  = 1024;
    localparam int DATA_WIDTH_DEF  = 32;

    // Fixed field widths of the channels.
    localparam int OPERAND_W  = 32;
    localparam int LEVEL_W    = 4;
    localparam int FUNC_W     = 3;
    localparam int NEXT_PC_W  = 10;
    localparam int CODE_LEN_W = 11;

    // Instruction classes.
    typedef enum logic [FUNC_W-1:0] {
        FN_LIT = 3'd0,
        FN_OPR = 3'd1,
        FN_LOD = 3'd2,
        FN_STO = 3'd3,
        FN_CAL = 3'd4,
        FN_INT = 3'd5,
        FN_JMP = 3'd6,
        FN_JPC = 3'd7
    } t_func;

    // OPR subcodes carried in the operand.
    localparam logic [OPERAND_W-1:0] OPR_RET = 32'd0;
    localparam logic [OPERAND_W-1:0] OPR_NEG = 32'd1;
    localparam logic [OPERAND_W-1:0] OPR_ADD = 32'd2;
    localparam logic [OPERAND_W-1:0] OPR_SUB = 32'd3;
    localparam logic [OPERAND_W-1:0] OPR_MUL = 32'd4;
    localparam logic [OPERAND_W-1:0] OPR_DIV = 32'd5;
    localparam logic [OPERAND_W-1:0] OPR_ODD = 32'd6;
    localparam logic [OPERAND_W-1:0] OPR_EQL = 32'd8;
    localparam logic [OPERAND_W-1:0] OPR_NEQ = 32'd9;
    localparam logic [OPERAND_W-1:0] OPR_LSS = 32'd10;
    localparam logic [OPERAND_W-1:0] OPR_GEQ = 32'd11;
    localparam logic [OPERAND_W-1:0] OPR_GTR = 32'd12;
    localparam logic [OPERAND_W-1:0] OPR_LEQ = 32'd13;
    localparam logic [OPERAND_W-1:0] OPR_WRT = 32'd14;
    localparam logic [OPERAND_W-1:0] OPR_NL  = 32'd15;
    localparam logic [OPERAND_W-1:0] OPR_RD  = 32'd16;

    // Error codes of a result.
    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_DIV0  = 2'd1,
        ERR_STACK = 2'd2
    } t_err;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CHAIN_RD,
        ST_CHAIN_WAIT,
        ST_CHAIN_DONE,
        ST_LOD_WAIT,
        ST_STO_WAIT,
        ST_CAL_SL,
        ST_CAL_RA,
        ST_JPC_WAIT,
        ST_RET_WAIT,
        ST_RET_BASE,
        ST_UN_WAIT,
        ST_BIN_X,
        ST_BIN_Y,
        ST_MUL,
        ST_DIV,
        ST_BIN_WR,
        ST_TARGET,
        ST_MOD,
        ST_FINISH
    } t_state;

endpackage

### sv/psm_if.sv
// Instruction channel.
interface psm_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [3:0]  level;
    logic [31:0] operand;
    logic [31:0] read_value;

    modport source (output valid, func, level, operand, read_value, input ready);
    modport sink   (input valid, func, level, operand, read_value, output ready);
endinterface

// Result channel.
interface psm_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  next_pc;
    logic        print_valid;
    logic [31:0] print_value;
    logic        print_newline;
    logic        halted;
    logic [1:0]  error_code;

    modport source (output valid, next_pc, print_valid, print_value, print_newline,
                    halted, error_code, input ready);
    modport sink   (input valid, next_pc, print_valid, print_value, print_newline,
                    halted, error_code, output ready);
endinterface

### sv/psm_ram.sv
module psm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/pcode_stack_machine_step_top.sv
// Sequence: an instruction runs from the accepting edge through its states to the loaded result;
// each static-chain level adds a link read, a multiply or a nonzero divide runs max(DATA_WIDTH,32)
// steps in the shared shift/add unit, and a jump target takes a reduction pass per 16 target bits
// when CODE_DEPTH is not a power of two.
// Throughput: one instruction in flight; the next beat is taken in the idle state after the result
// is loaded, and a stalled result holds the block.
// Reset (synchronous, active low) clears the state, counter, base, top, code length and result valid.
module pcode_stack_machine_step_top #(
    parameter int STACK_DEPTH = psm_pkg::STACK_DEPTH_DEF,
    parameter int CODE_DEPTH  = psm_pkg::CODE_DEPTH_DEF,
    parameter int DATA_WIDTH  = psm_pkg::DATA_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    psm_in_if.sink      i_in,
    psm_out_if.source   o_res
);

    localparam int DW   = DATA_WIDTH;
    localparam int UW   = (DW > 32) ? DW : 32;
    localparam int AW   = UW + 2;
    localparam int SAW  = $clog2(STACK_DEPTH);
    localparam int PCW  = $clog2(CODE_DEPTH);
    localparam int CW   = $clog2(UW);
    localparam bit CODE_POW2 = ((CODE_DEPTH & (CODE_DEPTH - 1)) == 0);
    localparam logic [CW-1:0] LAST_STEP = CW'(UW - 1);

    // Target reduction by the code depth, 16 bits per pass.
    localparam int NCH = (UW + 15) / 16;
    localparam int MQW = NCH * 16;
    localparam logic [1:0]  LAST_CHUNK = 2'(NCH - 1);
    localparam logic [31:0] RECIP      = 32'((64'd1 << 32) / 64'(CODE_DEPTH));
    localparam logic [17:0] MOD_C      = 18'(CODE_DEPTH);
    localparam logic [1:0]  MPH_MUL    = 2'd0;
    localparam logic [1:0]  MPH_SUB    = 2'd1;
    localparam logic [1:0]  MPH_FIX    = 2'd2;

    // Control state.
    psm_pkg::t_state r_state, n_state;
    logic [PCW-1:0]  r_pc, n_pc;
    logic [SAW-1:0]  r_base, n_base;
    logic [SAW:0]    r_top, n_top;
    logic [10:0]     r_code_len;
    logic            r_ovalid, n_ovalid;

    // Per-instruction working registers.
    psm_pkg::t_func  r_func, n_func;
    logic [3:0]      r_lvl, n_lvl;
    logic [31:0]     r_op, n_op;
    logic [31:0]     r_rdv, n_rdv;
    logic signed [AW-1:0] r_b, n_b;
    logic [DW-1:0]   r_x, n_x;
    logic [DW-1:0]   r_res, n_res;
    logic [UW-1:0]   r_tval, n_tval;
    logic [UW:0]     r_acc, n_acc;
    logic [UW-1:0]   r_q, n_q;
    logic [UW-1:0]   r_d, n_d;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_neg, n_neg;
    logic            r_sfault, n_sfault;
    logic            r_zfault, n_zfault;
    logic [PCW:0]    r_nfull, n_nfull;
    logic [DW-1:0]   r_pv, n_pv;
    logic            r_pvalid, n_pvalid;
    logic            r_pnl, n_pnl;
    logic            r_rd_ok;

    // Target reduction registers.
    logic [MQW-1:0]  r_mq, n_mq;
    logic [15:0]     r_mrem, n_mrem;
    logic [31:0]     r_mqa, n_mqa;
    logic [17:0]     r_mr, n_mr;
    logic [1:0]      r_mph, n_mph;
    logic [1:0]      r_mch, n_mch;

    // Result register.
    logic [9:0]      r_o_pc, n_o_pc;
    logic            r_o_pvalid, n_o_pvalid;
    logic [31:0]     r_o_pv, n_o_pv;
    logic            r_o_nl, n_o_nl;
    logic            r_o_halt, n_o_halt;
    psm_pkg::t_err   r_o_err, n_o_err;

    // Stack port requests.
    logic                 rd_req, wr_req;
    logic signed [AW-1:0] rd_a, wr_a;
    logic [DW-1:0]        wr_d;
    logic                 rd_ok, wr_ok, ram_we;
    logic [DW-1:0]        ram_q;

    // Shared shift/add unit.
    logic                 mul_mode;
    logic [UW:0]          alu_a, alu_res, div_sh;
    logic [UW:0]          stp_acc;
    logic [UW-1:0]        stp_q, stp_d;

    // Target reduction datapath.
    logic [31:0]          mod_x;
    logic [63:0]          mod_prod;
    logic [17:0]          mod_qc;
    logic [15:0]          mod_rem;

    // Decoded views.
    logic signed [AW-1:0] t_a, op_a, ea;
    logic [DW-1:0]        rd_val, op_d, rdv_d;
    logic [DW-1:0]        qmag;
    logic [PCW-1:0]       pc_new;

    function automatic logic signed [AW-1:0] sx_a(input logic [DW-1:0] v);
        sx_a = $signed({{(AW-DW){v[DW-1]}}, v});
    endfunction

    function automatic logic in_rng(input logic signed [AW-1:0] a);
        in_rng = !a[AW-1] && ($unsigned(a) < AW'(STACK_DEPTH));
    endfunction

    function automatic logic top_bad(input logic signed [AW-1:0] v);
        top_bad = v[AW-1] || ($unsigned(v) > AW'(STACK_DEPTH));
    endfunction

    function automatic logic [SAW:0] top_sat(input logic signed [AW-1:0] v);
        if (v[AW-1]) begin
            top_sat = '0;
        end else if ($unsigned(v) > AW'(STACK_DEPTH)) begin
            top_sat = (SAW+1)'(STACK_DEPTH);
        end else begin
            top_sat = v[SAW:0];
        end
    endfunction

    function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
        mag = v[DW-1] ? (~v + DW'(1)) : v;
    endfunction

    assign t_a    = $signed({{(AW-SAW-1){1'b0}}, r_top});
    assign op_a   = $signed({{(AW-32){r_op[31]}}, r_op});
    assign ea     = r_b + op_a;
    assign rd_val = r_rd_ok ? ram_q : '0;
    assign op_d   = DW'({{DW{r_op[31]}}, r_op});
    assign rdv_d  = DW'({{DW{r_rdv[31]}}, r_rdv});

    // Shift/add step: restoring division step, or one shift-add multiply step.
    assign mul_mode = (r_state == psm_pkg::ST_MUL);
    assign div_sh   = {r_acc[UW-1:0], r_q[UW-1]};
    assign alu_a    = mul_mode ? r_acc : div_sh;
    assign alu_res  = mul_mode ? (alu_a + {1'b0, r_d}) : (alu_a - {1'b0, r_d});

    always_comb begin
        if (mul_mode) begin
            stp_acc = r_q[0] ? alu_res : r_acc;
            stp_q   = r_q >> 1;
            stp_d   = r_d << 1;
        end else begin
            stp_acc = alu_res[UW] ? div_sh : alu_res;
            stp_q   = {r_q[UW-2:0], !alu_res[UW]};
            stp_d   = r_d;
        end
    end

    // Remainder pass: the reciprocal estimate of the quotient is low by at most one,
    // so one compare and subtract after the product subtract finishes the pass.
    assign mod_x    = {r_mrem, r_mq[MQW-1 -: 16]};
    assign mod_prod = {32'b0, mod_x} * {32'b0, RECIP};
    assign mod_qc   = r_mqa[17:0] * MOD_C;
    assign mod_rem  = (r_mr >= MOD_C) ? 16'(r_mr - MOD_C) : r_mr[15:0];

    assign qmag   = stp_q[DW-1:0];
    assign pc_new = (r_nfull == (PCW+1)'(CODE_DEPTH)) ? '0 : r_nfull[PCW-1:0];

    // Sequencer: next state, register updates and stack port requests.
    always_comb begin
        n_state    = r_state;
        n_pc       = r_pc;
        n_base     = r_base;
        n_top      = r_top;
        n_ovalid   = r_ovalid && !o_res.ready;
        n_func     = r_func;
        n_lvl      = r_lvl;
        n_op       = r_op;
        n_rdv      = r_rdv;
        n_b        = r_b;
        n_x        = r_x;
        n_res      = r_res;
        n_tval     = r_tval;
        n_acc      = r_acc;
        n_q        = r_q;
        n_d        = r_d;
        n_cnt      = r_cnt;
        n_neg      = r_neg;
        n_sfault   = r_sfault;
        n_zfault   = r_zfault;
        n_nfull    = r_nfull;
        n_pv       = r_pv;
        n_pvalid   = r_pvalid;
        n_pnl      = r_pnl;
        n_mq       = r_mq;
        n_mrem     = r_mrem;
        n_mqa      = r_mqa;
        n_mr       = r_mr;
        n_mph      = r_mph;
        n_mch      = r_mch;
        n_o_pc     = r_o_pc;
        n_o_pvalid = r_o_pvalid;
        n_o_pv     = r_o_pv;
        n_o_nl     = r_o_nl;
        n_o_halt   = r_o_halt;
        n_o_err    = r_o_err;
        rd_req     = 1'b0;
        rd_a       = '0;
        wr_req     = 1'b0;
        wr_a       = '0;
        wr_d       = '0;

        case (r_state)
            psm_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_func   = psm_pkg::t_func'(i_in.func);
                    n_lvl    = i_in.level;
                    n_op     = i_in.operand;
                    n_rdv    = i_in.read_value;
                    n_sfault = 1'b0;
                    n_zfault = 1'b0;
                    n_pvalid = 1'b0;
                    n_pnl    = 1'b0;
                    n_pv     = '0;
                    n_nfull  = {1'b0, r_pc} + (PCW+1)'(1);
                    n_state  = psm_pkg::ST_DISPATCH;
                end
            end

            psm_pkg::ST_DISPATCH: begin
                case (r_func)
                    psm_pkg::FN_LIT: begin
                        wr_req  = 1'b1;
                        wr_a    = t_a;
                        wr_d    = op_d;
                        n_top   = top_sat(t_a + AW'(1));
                        if (top_bad(t_a + AW'(1))) n_sfault = 1'b1;
                        n_state = psm_pkg::ST_FINISH;
                    end
                    psm_pkg::FN_INT: begin
                        n_top   = top_sat(t_a + op_a);
                        if (top_bad(t_a + op_a)) n_sfault = 1'b1;
                        n_state = psm_pkg::ST_FINISH;
                    end
                    psm_pkg::FN_JMP: begin
                        n_tval  = UW'(r_op);
                        n_state = psm_pkg::ST_TARGET;
                    end
                    psm_pkg::FN_JPC: begin
                        rd_req  = 1'b1;
                        rd_a    = t_a - AW'(1);
                        n_state = psm_pkg::ST_JPC_WAIT;
                    end
                    psm_pkg::FN_LOD, psm_pkg::FN_STO, psm_pkg::FN_CAL: begin
                        n_b     = $signed({{(AW-SAW){1'b0}}, r_base});
                        n_state = (r_lvl == '0) ? psm_pkg::ST_CHAIN_DONE
                                                : psm_pkg::ST_CHAIN_RD;
                    end
                    psm_pkg::FN_OPR: begin
                        case (r_op)
                            psm_pkg::OPR_RET: begin
                                rd_req  = 1'b1;
                                rd_a    = $signed({{(AW-SAW){1'b0}}, r_base}) + AW'(2);
                                n_state = psm_pkg::ST_RET_WAIT;
                            end
                            psm_pkg::OPR_NEG, psm_pkg::OPR_ODD, psm_pkg::OPR_WRT: begin
                                rd_req  = 1'b1;
                                rd_a    = t_a - AW'(1);
                                n_state = psm_pkg::ST_UN_WAIT;
                            end
                            psm_pkg::OPR_ADD, psm_pkg::OPR_SUB, psm_pkg::OPR_MUL,
                            psm_pkg::OPR_DIV, psm_pkg::OPR_EQL, psm_pkg::OPR_NEQ,
                            psm_pkg::OPR_LSS, psm_pkg::OPR_GEQ, psm_pkg::OPR_GTR,
                            psm_pkg::OPR_LEQ: begin
                                rd_req  = 1'b1;
                                rd_a    = t_a - AW'(2);
                                n_state = psm_pkg::ST_BIN_X;
                            end
                            psm_pkg::OPR_NL: begin
                                n_pnl   = 1'b1;
                                n_state = psm_pkg::ST_FINISH;
                            end
                            psm_pkg::OPR_RD: begin
                                wr_req  = 1'b1;
                                wr_a    = t_a;
                                wr_d    = rdv_d;
                                n_top   = top_sat(t_a + AW'(1));
                                if (top_bad(t_a + AW'(1))) n_sfault = 1'b1;
                                n_state = psm_pkg::ST_FINISH;
                            end
                            default: begin
                                n_state = psm_pkg::ST_FINISH;
                            end
                        endcase
                    end
                    default: begin
                        n_state = psm_pkg::ST_FINISH;
                    end
                endcase
            end

            // Static chain: follow the link one level per read.
            psm_pkg::ST_CHAIN_RD: begin
                rd_req  = 1'b1;
                rd_a    = r_b + AW'(1);
                n_state = psm_pkg::ST_CHAIN_WAIT;
            end

            psm_pkg::ST_CHAIN_WAIT: begin
                n_b     = sx_a(rd_val);
                n_lvl   = r_lvl - 4'd1;
                n_state = (r_lvl == 4'd1) ? psm_pkg::ST_CHAIN_DONE : psm_pkg::ST_CHAIN_RD;
            end

            psm_pkg::ST_CHAIN_DONE: begin
                case (r_func)
                    psm_pkg::FN_LOD: begin
                        rd_req  = 1'b1;
                        rd_a    = ea;
                        n_state = psm_pkg::ST_LOD_WAIT;
                    end
                    psm_pkg::FN_STO: begin
                        rd_req  = 1'b1;
                        rd_a    = t_a - AW'(1);
                        n_state = psm_pkg::ST_STO_WAIT;
                    end
                    default: begin
                        // Call: dynamic link first.
                        wr_req  = 1'b1;
                        wr_a    = t_a;
                        wr_d    = DW'({{DW{1'b0}}, r_base});
                        n_state = psm_pkg::ST_CAL_SL;
                    end
                endcase
            end

            psm_pkg::ST_LOD_WAIT: begin
                wr_req  = 1'b1;
                wr_a    = t_a;
                wr_d    = rd_val;
                n_top   = top_sat(t_a + AW'(1));
                if (top_bad(t_a + AW'(1))) n_sfault = 1'b1;
                n_state = psm_pkg::ST_FINISH;
            end

            psm_pkg::ST_STO_WAIT: begin
                wr_req  = 1'b1;
                wr_a    = ea;
                wr_d    = rd_val;
                n_top   = top_sat(t_a - AW'(1));
                if (top_bad(t_a - AW'(1))) n_sfault = 1'b1;
                n_state = psm_pkg::ST_FINISH;
            end

            psm_pkg::ST_CAL_SL: begin
                wr_req  = 1'b1;
                wr_a    = t_a + AW'(1);
                wr_d    = r_b[DW-1:0];
                n_state = psm_pkg::ST_CAL_RA;
            end

            psm_pkg::ST_CAL_RA: begin
                wr_req = 1'b1;
                wr_a   = t_a + AW'(2);
                wr_d   = DW'({{DW{1'b0}}, r_nfull});
                if (in_rng(t_a)) begin
                    n_base = t_a[SAW-1:0];
                end else begin
                    n_sfault = 1'b1;
                end
                n_tval  = UW'(r_op);
                n_state = psm_pkg::ST_TARGET;
            end

            psm_pkg::ST_JPC_WAIT: begin
                n_tval  = UW'(r_op);
                n_state = (rd_val == '0) ? psm_pkg::ST_TARGET : psm_pkg::ST_FINISH;
            end

            // Return: saved address arrives, then the dynamic link.
            psm_pkg::ST_RET_WAIT: begin
                n_tval  = UW'(rd_val);
                rd_req  = 1'b1;
                rd_a    = $signed({{(AW-SAW){1'b0}}, r_base});
                n_state = psm_pkg::ST_RET_BASE;
            end

            psm_pkg::ST_RET_BASE: begin
                n_top = {1'b0, r_base};
                if (in_rng(sx_a(rd_val))) begin
                    n_base = rd_val[SAW-1:0];
                end else begin
                    n_sfault = 1'b1;
                end
                n_state = psm_pkg::ST_TARGET;
            end

            psm_pkg::ST_UN_WAIT: begin
                case (r_op)
                    psm_pkg::OPR_NEG: begin
                        wr_req = 1'b1;
                        wr_a   = t_a - AW'(1);
                        wr_d   = DW'(0) - rd_val;
                    end
                    psm_pkg::OPR_ODD: begin
                        wr_req = 1'b1;
                        wr_a   = t_a - AW'(1);
                        wr_d   = DW'(rd_val[0]);
                    end
                    default: begin
                        n_pvalid = 1'b1;
                        n_pv     = rd_val;
                    end
                endcase
                n_state = psm_pkg::ST_FINISH;
            end

            psm_pkg::ST_BIN_X: begin
                n_x     = rd_val;
                rd_req  = 1'b1;
                rd_a    = t_a - AW'(1);
                n_state = psm_pkg::ST_BIN_Y;
            end

            psm_pkg::ST_BIN_Y: begin
                n_state = psm_pkg::ST_BIN_WR;
                case (r_op)
                    psm_pkg::OPR_ADD: n_res = r_x + rd_val;
                    psm_pkg::OPR_SUB: n_res = r_x - rd_val;
                    psm_pkg::OPR_EQL: n_res = DW'(r_x == rd_val);
                    psm_pkg::OPR_NEQ: n_res = DW'(r_x != rd_val);
                    psm_pkg::OPR_LSS: n_res = DW'($signed(r_x) < $signed(rd_val));
                    psm_pkg::OPR_GEQ: n_res = DW'($signed(r_x) >= $signed(rd_val));
                    psm_pkg::OPR_GTR: n_res = DW'($signed(r_x) > $signed(rd_val));
                    psm_pkg::OPR_LEQ: n_res = DW'($signed(r_x) <= $signed(rd_val));
                    psm_pkg::OPR_MUL: begin
                        n_acc   = '0;
                        n_d     = UW'(r_x);
                        n_q     = UW'(rd_val);
                        n_cnt   = '0;
                        n_state = psm_pkg::ST_MUL;
                    end
                    default: begin
                        if (rd_val == '0) begin
                            n_zfault = 1'b1;
                            n_res    = '0;
                        end else begin
                            n_acc   = '0;
                            n_q     = UW'(mag(r_x));
                            n_d     = UW'(mag(rd_val));
                            n_neg   = r_x[DW-1] ^ rd_val[DW-1];
                            n_cnt   = '0;
                            n_state = psm_pkg::ST_DIV;
                        end
                    end
                endcase
            end

            psm_pkg::ST_MUL: begin
                n_acc = stp_acc;
                n_q   = stp_q;
                n_d   = stp_d;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == LAST_STEP) begin
                    n_res   = stp_acc[DW-1:0];
                    n_state = psm_pkg::ST_BIN_WR;
                end
            end

            psm_pkg::ST_DIV: begin
                n_acc = stp_acc;
                n_q   = stp_q;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == LAST_STEP) begin
                    n_res   = r_neg ? (DW'(0) - qmag) : qmag;
                    n_state = psm_pkg::ST_BIN_WR;
                end
            end

            psm_pkg::ST_BIN_WR: begin
                wr_req  = 1'b1;
                wr_a    = t_a - AW'(2);
                wr_d    = r_res;
                n_top   = top_sat(t_a - AW'(1));
                if (top_bad(t_a - AW'(1))) n_sfault = 1'b1;
                n_state = psm_pkg::ST_FINISH;
            end

            // Jump target reduced modulo the code depth.
            psm_pkg::ST_TARGET: begin
                if (CODE_POW2) begin
                    n_nfull = {1'b0, r_tval[PCW-1:0]};
                    n_state = psm_pkg::ST_FINISH;
                end else begin
                    n_mq    = MQW'(r_tval);
                    n_mrem  = '0;
                    n_mph   = MPH_MUL;
                    n_mch   = '0;
                    n_state = psm_pkg::ST_MOD;
                end
            end

            // One 16-bit chunk per pass, most significant first: multiply, subtract, then fix.
            psm_pkg::ST_MOD: begin
                case (r_mph)
                    MPH_MUL: begin
                        n_mqa = mod_prod[63:32];
                        n_mph = MPH_SUB;
                    end
                    MPH_SUB: begin
                        n_mr  = mod_x[17:0] - mod_qc;
                        n_mph = MPH_FIX;
                    end
                    default: begin
                        n_mrem = mod_rem;
                        n_mq   = r_mq << 16;
                        n_mph  = MPH_MUL;
                        n_mch  = r_mch + 2'd1;
                        if (r_mch == LAST_CHUNK) begin
                            n_nfull = (PCW+1)'(mod_rem);
                            n_state = psm_pkg::ST_FINISH;
                        end
                    end
                endcase
            end

            // Commit the counter and load the result register.
            psm_pkg::ST_FINISH: begin
                if (!r_ovalid || o_res.ready) begin
                    n_pc       = pc_new;
                    n_ovalid   = 1'b1;
                    n_o_pc     = 10'({10'b0, pc_new});
                    n_o_pvalid = r_pvalid;
                    n_o_pv     = 32'({{32{r_pv[DW-1]}}, r_pv});
                    n_o_nl     = r_pnl;
                    n_o_halt   = (32'(r_nfull) >= 32'(r_code_len));
                    n_o_err    = r_sfault ? psm_pkg::ERR_STACK :
                                 (r_zfault ? psm_pkg::ERR_DIV0 : psm_pkg::ERR_NONE);
                    n_state    = psm_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = psm_pkg::ST_IDLE;
            end
        endcase

        // Out-of-range stack accesses flag a fault; writes are dropped.
        if (rd_req && !rd_ok) n_sfault = 1'b1;
        if (wr_req && !wr_ok) n_sfault = 1'b1;
    end

    assign rd_ok  = in_rng(rd_a);
    assign wr_ok  = in_rng(wr_a);
    assign ram_we = wr_req && wr_ok;

    psm_ram #(
        .WIDTH (DW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_a[SAW-1:0]),
        .i_wdata (wr_d),
        .i_raddr (rd_a[SAW-1:0]),
        .o_rdata (ram_q)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= psm_pkg::ST_IDLE;
            r_pc       <= '0;
            r_base     <= '0;
            r_top      <= '0;
            r_code_len <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pc     <= n_pc;
            r_base   <= n_base;
            r_top    <= n_top;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_code_len <= i_cfg_wdata;
            end
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_lvl      <= n_lvl;
        r_op       <= n_op;
        r_rdv      <= n_rdv;
        r_b        <= n_b;
        r_x        <= n_x;
        r_res      <= n_res;
        r_tval     <= n_tval;
        r_acc      <= n_acc;
        r_q        <= n_q;
        r_d        <= n_d;
        r_cnt      <= n_cnt;
        r_neg      <= n_neg;
        r_sfault   <= n_sfault;
        r_zfault   <= n_zfault;
        r_nfull    <= n_nfull;
        r_pv       <= n_pv;
        r_pvalid   <= n_pvalid;
        r_pnl      <= n_pnl;
        r_rd_ok    <= rd_ok;
        r_mq       <= n_mq;
        r_mrem     <= n_mrem;
        r_mqa      <= n_mqa;
        r_mr       <= n_mr;
        r_mph      <= n_mph;
        r_mch      <= n_mch;
        r_o_pc     <= n_o_pc;
        r_o_pvalid <= n_o_pvalid;
        r_o_pv     <= n_o_pv;
        r_o_nl     <= n_o_nl;
        r_o_halt   <= n_o_halt;
        r_o_err    <= n_o_err;
    end

    assign i_in.ready          = (r_state == psm_pkg::ST_IDLE);
    assign o_res.valid         = r_ovalid;
    assign o_res.next_pc       = r_o_pc;
    assign o_res.print_valid   = r_o_pvalid;
    assign o_res.print_value   = r_o_pv;
    assign o_res.print_newline = r_o_nl;
    assign o_res.halted        = r_o_halt;
    assign o_res.error_code    = r_o_err;

endmodule
